FILE: sv/fts_pkg.sv
package fts_pkg;

   // Field widths fixed by the interface.
   localparam int DRAW_W = 24;
   localparam int TIME_W = 40;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int FPS_W = 24;
   localparam int FRAC_W = 17;
   localparam int HELD_W = 8;
   localparam int CAP_W = 8;

   // Default storage depths.
   localparam int DRAW_DEPTH_DEF = 128;
   localparam int ARRIVAL_DEPTH_DEF = 256;

   // Shared divider sizing: numerator covers the scaled rate, the draw sum and
   // the shifted over count; denominator covers a full time span.
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 40;

   // One second in microseconds times 256 for the 16.8 rate.
   localparam logic [27:0] FPS_SCALE = 28'd256000000;
   localparam logic [FPS_W-1:0] FPS_MAX = {FPS_W{1'b1}};

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd2;

   // Register reset values.
   localparam int CAPACITY_RST = 128;
   localparam logic [DRAW_W-1:0] BUDGET_RST = 24'd16667;
   localparam logic [DRAW_W-1:0] WINDOW_RST = 24'd1000000;

   // Request kinds.
   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK = 1'b1;

endpackage

FILE: sv/fts_div.sv
module fts_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fts_pkg::DIV_NUM_W-1:0] num,
   input  logic [fts_pkg::DIV_DEN_W-1:0] den,
   output logic                          done,
   output logic [fts_pkg::DIV_NUM_W-1:0] quo
);
   import fts_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   // One restoring step per cycle: shift in the next numerator bit and try
   // to take the divisor away.
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits = trial >= {1'b0, den_ff};
      rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : DIV_DEN_W'(trial);
      quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= '0;
            quo_ff <= num;
            den_ff <= den;
            cnt_ff <= CNT_W'(DIV_NUM_W);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;

endmodule

FILE: sv/frame_time_window_stats_unit.sv
// Frame timing statistics over a window of recent frames.
// A request carries req_type (frame or tick), req_draw_us and req_now_us and
// is taken when req_valid is high and req_stall is low. A frame request adds
// its draw time to a ring of the newest capacity samples and its timestamp to
// an arrival ring; every request then expires arrivals older than the window.
// One response per request on the rsp_ channel gives the frame rate, the mean
// and peak draw time, the over-budget fraction and the held sample count.
// The scan reads the held draw samples one per cycle from the draw memory,
// and each expired arrival passes through the arrival memory read port;
// the three divisions share one bit-serial divider of 48 steps. One request
// is worked on at a time and req_stall stays high until its response is
// registered. A response held by rsp_stall blocks the next response only.
// Configuration writes on csr_ are taken while idle, and req_stall stays high
// while csr_valid is high; lowering capacity drops the oldest samples with
// csr_ready low meanwhile.
// Reset empties both rings and loads the register defaults; no clearing pass.
module frame_time_window_stats_unit #(
   parameter int DRAW_DEPTH = fts_pkg::DRAW_DEPTH_DEF,
   parameter int ARRIVAL_DEPTH = fts_pkg::ARRIVAL_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic [fts_pkg::DRAW_W-1:0]     req_draw_us,
   input  logic [fts_pkg::TIME_W-1:0]     req_now_us,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fts_pkg::FPS_W-1:0]      rsp_fps_q8,
   output logic [fts_pkg::DRAW_W-1:0]     rsp_mean_draw_us,
   output logic [fts_pkg::DRAW_W-1:0]     rsp_peak_draw_us,
   output logic [fts_pkg::FRAC_W-1:0]     rsp_over_frac_q16,
   output logic [fts_pkg::HELD_W-1:0]     rsp_samples_held,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fts_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fts_pkg::*;

   localparam int DIDX_W = $clog2(DRAW_DEPTH);
   localparam int DCNT_W = $clog2(DRAW_DEPTH + 1);
   localparam int AIDX_W = $clog2(ARRIVAL_DEPTH);
   localparam int ACNT_W = $clog2(ARRIVAL_DEPTH + 1);
   localparam int SUM_W = DRAW_W + DCNT_W;
   localparam int PROD_W = ACNT_W + 28;
   localparam int CAP_RST = (CAPACITY_RST > DRAW_DEPTH) ? DRAW_DEPTH : CAPACITY_RST;

   typedef enum logic [3:0] {
      S_IDLE, S_DROP_CHK, S_DROP_RD, S_DROP_SUB, S_INS, S_EXP_RD, S_EXP_CHK,
      S_FPS_RD0, S_FPS_RD1, S_FPS_CALC, S_FPS_DIV, S_SCAN_INIT, S_SCAN,
      S_MEAN_DIV, S_FRAC_DIV, S_RESULT
   } state_type;

   state_type state_ff, state_in;

   logic                  type_ff, type_in;
   logic [DRAW_W-1:0]     draw_ff, draw_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [DCNT_W-1:0]     cap_ff, cap_in;
   logic [DRAW_W-1:0]     budget_ff, budget_in;
   logic [DRAW_W-1:0]     window_ff, window_in;
   logic [DIDX_W-1:0]     dhead_ff, dhead_in;
   logic [DCNT_W-1:0]     dcount_ff, dcount_in;
   logic [SUM_W-1:0]      dsum_ff, dsum_in;
   logic [AIDX_W-1:0]     ahead_ff, ahead_in;
   logic [ACNT_W-1:0]     acount_ff, acount_in;
   logic                  trim_ff, trim_in;
   logic [TIME_W-1:0]     first_ff, first_in;
   logic [FPS_W-1:0]      fps_ff, fps_in;
   logic [DRAW_W-1:0]     mean_ff, mean_in;
   logic [DRAW_W-1:0]     peak_ff, peak_in;
   logic [DCNT_W-1:0]     over_ff, over_in;
   logic [DCNT_W-1:0]     sidx_ff, sidx_in;
   logic                  pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FPS_W-1:0]      rsp_fps_ff, rsp_fps_in;
   logic [DRAW_W-1:0]     rsp_mean_ff, rsp_mean_in;
   logic [DRAW_W-1:0]     rsp_peak_ff, rsp_peak_in;
   logic [FRAC_W-1:0]     rsp_frac_ff, rsp_frac_in;
   logic [HELD_W-1:0]     rsp_held_ff, rsp_held_in;

   // Draw and arrival memories, one port each.
   logic [DRAW_W-1:0]     draw_mem [DRAW_DEPTH];
   logic [TIME_W-1:0]     arr_mem [ARRIVAL_DEPTH];
   logic [DRAW_W-1:0]     draw_rd_ff;
   logic [TIME_W-1:0]     arr_rd_ff;
   logic [DIDX_W-1:0]     draw_addr;
   logic [AIDX_W-1:0]     arr_addr;
   logic                  draw_we;
   logic                  arr_we;

   // Shared divider hookup.
   logic                  div_start;
   logic [DIV_NUM_W-1:0]  div_num;
   logic [DIV_DEN_W-1:0]  div_den;
   logic                  div_done;
   logic [DIV_NUM_W-1:0]  div_quo;

   logic                  req_take;
   logic                  csr_take;
   logic                  rsp_take;
   logic [7:0]            cap_raw;
   logic [TIME_W-1:0]     age;
   logic [ACNT_W-1:0]     acount_less;
   logic [PROD_W-1:0]     fps_prod;

   // Ring positions wrap at the depth, which need not be a power of two.
   function automatic logic [DIDX_W-1:0] draw_pos(logic [DIDX_W-1:0] base,
                                                  logic [DCNT_W-1:0] offs);
      logic [DIDX_W+1:0] s;
      s = (DIDX_W+2)'(base) + (DIDX_W+2)'(offs);
      if (s >= (DIDX_W+2)'(DRAW_DEPTH)) s = s - (DIDX_W+2)'(DRAW_DEPTH);
      return DIDX_W'(s);
   endfunction

   function automatic logic [AIDX_W-1:0] arr_pos(logic [AIDX_W-1:0] base,
                                                 logic [ACNT_W-1:0] offs);
      logic [AIDX_W+1:0] s;
      s = (AIDX_W+2)'(base) + (AIDX_W+2)'(offs);
      if (s >= (AIDX_W+2)'(ARRIVAL_DEPTH)) s = s - (AIDX_W+2)'(ARRIVAL_DEPTH);
      return AIDX_W'(s);
   endfunction

   assign req_take = req_valid && !req_stall;
   assign csr_take = csr_valid && csr_ready;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign cap_raw = csr_wdata[7:0];
   assign age = (now_ff > arr_rd_ff) ? now_ff - arr_rd_ff : '0;
   assign acount_less = acount_ff - 1'b1;
   assign fps_prod = PROD_W'(acount_less) * PROD_W'(FPS_SCALE);

   // Sequencer: capacity trim, insert, expiry walk, rate, scan and divisions.
   always_comb begin
      state_in = state_ff;
      type_in = type_ff;
      draw_in = draw_ff;
      now_in = now_ff;
      cap_in = cap_ff;
      budget_in = budget_ff;
      window_in = window_ff;
      dhead_in = dhead_ff;
      dcount_in = dcount_ff;
      dsum_in = dsum_ff;
      ahead_in = ahead_ff;
      acount_in = acount_ff;
      trim_in = trim_ff;
      first_in = first_ff;
      fps_in = fps_ff;
      mean_in = mean_ff;
      peak_in = peak_ff;
      over_in = over_ff;
      sidx_in = sidx_ff;
      pend_in = pend_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_fps_in = rsp_fps_ff;
      rsp_mean_in = rsp_mean_ff;
      rsp_peak_in = rsp_peak_ff;
      rsp_frac_in = rsp_frac_ff;
      rsp_held_in = rsp_held_ff;
      draw_addr = dhead_ff;
      arr_addr = ahead_ff;
      draw_we = 1'b0;
      arr_we = 1'b0;
      div_start = 1'b0;
      div_num = DIV_NUM_W'(dsum_ff);
      div_den = DIV_DEN_W'(dcount_ff);

      case (state_ff)
         S_IDLE: begin
            if (csr_take) begin
               case (csr_index)
                  CSR_CAPACITY: begin
                     if (cap_raw == 8'd0) begin
                        cap_in = DCNT_W'(1);
                     end else if (int'(cap_raw) > DRAW_DEPTH) begin
                        cap_in = DCNT_W'(DRAW_DEPTH);
                     end else begin
                        cap_in = DCNT_W'(cap_raw);
                     end
                     trim_in = 1'b1;
                     state_in = S_DROP_CHK;
                  end
                  CSR_BUDGET: budget_in = csr_wdata;
                  CSR_WINDOW: window_in = csr_wdata;
                  default: ;
               endcase
            end else if (req_take) begin
               type_in = req_type;
               draw_in = req_draw_us;
               now_in = req_now_us;
               trim_in = 1'b0;
               state_in = (req_type == REQ_FRAME) ? S_DROP_CHK : S_EXP_RD;
            end
         end
         // Drop the oldest samples until the new count fits the capacity.
         S_DROP_CHK: begin
            if (trim_ff ? (dcount_ff > cap_ff) : (dcount_ff >= cap_ff)) begin
               state_in = S_DROP_RD;
            end else begin
               state_in = trim_ff ? S_IDLE : S_INS;
            end
         end
         S_DROP_RD: begin
            state_in = S_DROP_SUB;
         end
         S_DROP_SUB: begin
            dsum_in = dsum_ff - SUM_W'(draw_rd_ff);
            dhead_in = draw_pos(dhead_ff, DCNT_W'(1));
            dcount_in = dcount_ff - 1'b1;
            state_in = S_DROP_CHK;
         end
         // Store the new sample and its arrival; a full arrival ring loses
         // its oldest entry.
         S_INS: begin
            draw_addr = draw_pos(dhead_ff, dcount_ff);
            draw_we = 1'b1;
            dsum_in = dsum_ff + SUM_W'(draw_ff);
            dcount_in = dcount_ff + 1'b1;
            arr_we = 1'b1;
            if (acount_ff == ACNT_W'(ARRIVAL_DEPTH)) begin
               arr_addr = ahead_ff;
               ahead_in = arr_pos(ahead_ff, ACNT_W'(1));
            end else begin
               arr_addr = arr_pos(ahead_ff, acount_ff);
               acount_in = acount_ff + 1'b1;
            end
            state_in = S_EXP_RD;
         end
         // Walk the oldest arrivals out of the window.
         S_EXP_RD: begin
            state_in = (acount_ff == '0) ? S_FPS_RD0 : S_EXP_CHK;
         end
         S_EXP_CHK: begin
            if (age > TIME_W'(window_ff)) begin
               ahead_in = arr_pos(ahead_ff, ACNT_W'(1));
               acount_in = acount_ff - 1'b1;
               state_in = S_EXP_RD;
            end else begin
               state_in = S_FPS_RD0;
            end
         end
         // Fetch oldest and newest arrival for the span.
         S_FPS_RD0: begin
            fps_in = '0;
            state_in = (acount_ff < ACNT_W'(2)) ? S_SCAN_INIT : S_FPS_RD1;
         end
         S_FPS_RD1: begin
            first_in = arr_rd_ff;
            arr_addr = arr_pos(ahead_ff, acount_less);
            state_in = S_FPS_CALC;
         end
         S_FPS_CALC: begin
            if (arr_rd_ff > first_ff) begin
               div_num = DIV_NUM_W'(fps_prod);
               div_den = DIV_DEN_W'(arr_rd_ff - first_ff);
               div_start = 1'b1;
               state_in = S_FPS_DIV;
            end else begin
               state_in = S_SCAN_INIT;
            end
         end
         S_FPS_DIV: begin
            if (div_done) begin
               fps_in = (div_quo > DIV_NUM_W'(FPS_MAX)) ? FPS_MAX : FPS_W'(div_quo);
               state_in = S_SCAN_INIT;
            end
         end
         S_SCAN_INIT: begin
            sidx_in = '0;
            pend_in = 1'b0;
            peak_in = '0;
            over_in = '0;
            state_in = S_SCAN;
         end
         // One sample read per cycle; the compare works on the previous read.
         S_SCAN: begin
            pend_in = 1'b0;
            if (sidx_ff < dcount_ff) begin
               draw_addr = draw_pos(dhead_ff, sidx_ff);
               sidx_in = sidx_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (draw_rd_ff > peak_ff) peak_in = draw_rd_ff;
               if (draw_rd_ff > budget_ff) over_in = over_ff + 1'b1;
            end
            if (sidx_ff == dcount_ff && !pend_ff) begin
               if (dcount_ff == '0) begin
                  mean_in = '0;
                  state_in = S_RESULT;
               end else begin
                  div_start = 1'b1;
                  state_in = S_MEAN_DIV;
               end
            end
         end
         S_MEAN_DIV: begin
            if (div_done) begin
               mean_in = DRAW_W'(div_quo);
               div_num = DIV_NUM_W'({over_ff, 16'd0});
               div_start = 1'b1;
               state_in = S_FRAC_DIV;
            end
         end
         S_FRAC_DIV: begin
            if (div_done) begin
               state_in = S_RESULT;
            end
         end
         // Load the response register once the previous one is gone.
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_fps_in = fps_ff;
               rsp_mean_in = mean_ff;
               rsp_peak_in = peak_ff;
               rsp_frac_in = (dcount_ff == '0) ? '0 : FRAC_W'(div_quo);
               rsp_held_in = HELD_W'(dcount_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff <= DCNT_W'(CAP_RST);
         budget_ff <= BUDGET_RST;
         window_ff <= WINDOW_RST;
         dhead_ff <= '0;
         dcount_ff <= '0;
         dsum_ff <= '0;
         ahead_ff <= '0;
         acount_ff <= '0;
         trim_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff <= cap_in;
         budget_ff <= budget_in;
         window_ff <= window_in;
         dhead_ff <= dhead_in;
         dcount_ff <= dcount_in;
         dsum_ff <= dsum_in;
         ahead_ff <= ahead_in;
         acount_ff <= acount_in;
         trim_ff <= trim_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff <= type_in;
      draw_ff <= draw_in;
      now_ff <= now_in;
      first_ff <= first_in;
      fps_ff <= fps_in;
      mean_ff <= mean_in;
      peak_ff <= peak_in;
      over_ff <= over_in;
      sidx_ff <= sidx_in;
      rsp_fps_ff <= rsp_fps_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_peak_ff <= rsp_peak_in;
      rsp_frac_ff <= rsp_frac_in;
      rsp_held_ff <= rsp_held_in;
   end

   // Draw memory with registered read.
   always_ff @(posedge clock) begin
      if (draw_we) draw_mem[draw_addr] <= draw_ff;
      draw_rd_ff <= draw_mem[draw_addr];
   end

   // Arrival memory with registered read.
   always_ff @(posedge clock) begin
      if (arr_we) arr_mem[arr_addr] <= now_ff;
      arr_rd_ff <= arr_mem[arr_addr];
   end

   fts_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // A register write takes the idle slot, so requests wait behind it.
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_fps_q8 = rsp_fps_ff;
   assign rsp_mean_draw_us = rsp_mean_ff;
   assign rsp_peak_draw_us = rsp_peak_ff;
   assign rsp_over_frac_q16 = rsp_frac_ff;
   assign rsp_samples_held = rsp_held_ff;

   // The held count never exceeds the capacity between requests.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (dcount_ff <= cap_ff))
      else $error("draw count above capacity while idle");

   // The arrival count stays within the ring.
   assert property (@(posedge clock) disable iff (reset)
      acount_ff <= ACNT_W'(ARRIVAL_DEPTH))
      else $error("arrival count above depth");

   // A new response only comes from the result step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("response raised outside result step");

   // The divider finishes only while a division is awaited.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_FPS_DIV || state_ff == S_MEAN_DIV ||
                    state_ff == S_FRAC_DIV))
      else $error("divider finished with nobody waiting");

endmodule
